// ----- src/spd_pkg.sv -----
// Shared types, constants and the CRC-16 byte step for the servo packet deframer.
// No dependencies; every other file of the block imports this package.
package spd_pkg;

    localparam int BYTE_W = 8;
    localparam int WORD_W = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [23:0] HDR_WORD = 24'hFFFFFD;
    localparam logic [15:0] CRC_POLY = 16'h8005;
    localparam logic [15:0] PARAM_OVERHEAD = 16'd3;
    localparam logic [7:0] RST_DEVICE_ID = 8'd5;
    localparam logic [15:0] RST_MAX_LENGTH = 16'd29;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_RSV   = 3'd1,
        PH_ID    = 3'd2,
        PH_LENL  = 3'd3,
        PH_LENH  = 3'd4,
        PH_INSTR = 3'd5,
        PH_PARAM = 3'd6,
        PH_CRC   = 3'd7
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEVICE_ID  = 1'b0,
        CFG_MAX_LENGTH = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        KIND_PARAM = 1'b0,
        KIND_END   = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind             result_kind;
        logic [BYTE_W-1:0] data_byte;
        logic [WORD_W-1:0] param_index;
        logic [BYTE_W-1:0] frame_id;
        logic [BYTE_W-1:0] instruction_code;
        logic [WORD_W-1:0] length_value;
        logic [WORD_W-1:0] crc_received;
        logic              crc_ok;
        logic              addressed;
        logic              length_ok;
    } t_result;

    // CRC-16, MSB first, one byte per call.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // CRC after the three header bytes, starting from zero.
    localparam logic [15:0] HDR_CRC =
        crc16_byte(crc16_byte(crc16_byte(16'h0000, 8'hFF), 8'hFF), 8'hFD);

endpackage

// ----- src/spd_ifs.sv -----
// Valid/ready channel interfaces for the servo packet deframer: received bytes and results.
// Depends on spd_pkg for field widths.
interface spd_rx_if import spd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface spd_res_if import spd_pkg::*;;
    logic              valid;
    logic              ready;
    logic              result_kind;
    logic [BYTE_W-1:0] data_byte;
    logic [WORD_W-1:0] param_index;
    logic [BYTE_W-1:0] frame_id;
    logic [BYTE_W-1:0] instruction_code;
    logic [WORD_W-1:0] length_value;
    logic [WORD_W-1:0] crc_received;
    logic              crc_ok;
    logic              addressed;
    logic              length_ok;

    modport source (
        output valid, output result_kind, output data_byte, output param_index,
        output frame_id, output instruction_code, output length_value,
        output crc_received, output crc_ok, output addressed, output length_ok,
        input ready
    );
    modport sink (
        input valid, input result_kind, input data_byte, input param_index,
        input frame_id, input instruction_code, input length_value,
        input crc_received, input crc_ok, input addressed, input length_ok,
        output ready
    );
endinterface

// ----- src/servo_packet_deframer.sv -----
// Servo serial-link packet deframer: header hunt, field capture, parameter bytes, CRC check.
// Depends on spd_pkg and the channel interfaces in spd_ifs.sv.
//
//   channel   dir  handshake          payload
//   i_rx      in   valid/ready        rx_byte (8)
//   o_res     out  valid/ready        result_kind, data_byte, param_index, frame_id,
//                                     instruction_code, length_value, crc_received,
//                                     crc_ok, addressed, length_ok
//   i_cfg_*   in   write enable only  index (1), data (16)
//
// One byte per cycle sustained while results are taken: each byte goes through an input
// register, one pass of the parse logic (a byte-wide CRC step and a 16-bit compare) and
// into the result register, from which o_res presents its result.
// Synchronous active-low reset returns to header hunt with an empty window and loads the
// register defaults (device_id 5, max_length 29).
// A stalled result holds the result register; the input register still takes one more
// byte, then i_rx.ready drops until the result is taken.
module servo_packet_deframer import spd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    spd_rx_if.sink               i_rx,
    spd_res_if.source            o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    // Configuration registers
    logic [BYTE_W-1:0] r_device_id;
    logic [WORD_W-1:0] r_max_length;

    // Input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // Parse state
    t_phase            r_phase, n_phase;
    logic [WORD_W-1:0] r_window, n_window;
    logic [BYTE_W-1:0] r_id, n_id;
    logic [WORD_W-1:0] r_len, n_len;
    logic [BYTE_W-1:0] r_instr, n_instr;
    logic [WORD_W-1:0] r_param_cnt, n_param_cnt;
    logic [WORD_W-1:0] r_crc, n_crc;
    logic [BYTE_W-1:0] r_crc_lo, n_crc_lo;

    // Result register
    logic    r_out_valid, n_out_valid;
    t_result r_out, n_out;
    logic    res_emit;

    logic              proc;
    logic [23:0]       win;
    logic [WORD_W-1:0] param_total;
    logic [WORD_W-1:0] cnt_inc;
    logic [WORD_W-1:0] crc_step;
    logic [WORD_W-1:0] crc_rx;
    logic              len_ok;

    // Work on the held byte when the result register is free or being emptied.
    assign proc        = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready  = !r_in_valid || proc;

    assign win         = {r_window, r_in_byte};
    assign len_ok      = (r_len <= r_max_length);
    assign param_total = (!len_ok || r_len <= PARAM_OVERHEAD) ? '0 : (r_len - PARAM_OVERHEAD);
    assign cnt_inc     = r_param_cnt + 16'd1;
    assign crc_step    = crc16_byte(r_crc, r_in_byte);
    assign crc_rx      = {r_in_byte, r_crc_lo};

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_id  <= RST_DEVICE_ID;
            r_max_length <= RST_MAX_LENGTH;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_DEVICE_ID:  r_device_id  <= i_cfg_data[BYTE_W-1:0];
                CFG_MAX_LENGTH: r_max_length <= i_cfg_data;
            endcase
        end
    end

    // Input register: load on accept, drop once processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= (i_rx.valid && i_rx.ready) || (r_in_valid && !proc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (proc) begin
            unique case (r_phase)
                PH_HUNT:  n_phase = (win == HDR_WORD) ? PH_RSV : PH_HUNT;
                PH_RSV:   n_phase = PH_ID;
                PH_ID:    n_phase = PH_LENL;
                PH_LENL:  n_phase = PH_LENH;
                PH_LENH:  n_phase = PH_INSTR;
                PH_INSTR: n_phase = (param_total != '0) ? PH_PARAM : PH_CRC;
                PH_PARAM: n_phase = (cnt_inc >= param_total) ? PH_CRC : PH_PARAM;
                PH_CRC:   n_phase = (r_param_cnt == '0) ? PH_CRC : PH_HUNT;
            endcase
        end
    end

    // Datapath and result for the current byte
    always_comb begin
        n_window    = r_window;
        n_id        = r_id;
        n_len       = r_len;
        n_instr     = r_instr;
        n_param_cnt = r_param_cnt;
        n_crc       = r_crc;
        n_crc_lo    = r_crc_lo;
        res_emit    = 1'b0;

        n_out                  = '0;
        n_out.frame_id         = r_id;
        n_out.instruction_code = r_instr;
        n_out.length_value     = r_len;
        n_out.addressed        = (r_id == r_device_id);
        n_out.length_ok        = len_ok;

        if (proc) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (win == HDR_WORD) begin
                        n_window = '0;
                        n_crc    = HDR_CRC;
                    end else begin
                        n_window = win[WORD_W-1:0];
                    end
                end
                PH_RSV: begin
                    n_crc = crc_step;
                end
                PH_ID: begin
                    n_crc = crc_step;
                    n_id  = r_in_byte;
                end
                PH_LENL: begin
                    n_crc = crc_step;
                    n_len = {8'h00, r_in_byte};
                end
                PH_LENH: begin
                    n_crc = crc_step;
                    n_len = {r_in_byte, r_len[7:0]};
                end
                PH_INSTR: begin
                    n_crc       = crc_step;
                    n_instr     = r_in_byte;
                    n_param_cnt = '0;
                end
                PH_PARAM: begin
                    n_crc             = crc_step;
                    res_emit          = 1'b1;
                    n_out.result_kind = KIND_PARAM;
                    n_out.data_byte   = r_in_byte;
                    n_out.param_index = r_param_cnt;
                    n_param_cnt       = (cnt_inc >= param_total) ? '0 : cnt_inc;
                end
                PH_CRC: begin
                    if (r_param_cnt == '0) begin
                        n_crc_lo    = r_in_byte;
                        n_param_cnt = 16'd1;
                    end else begin
                        // Packet closes: report and restart the header hunt.
                        res_emit           = 1'b1;
                        n_out.result_kind  = KIND_END;
                        n_out.crc_received = crc_rx;
                        n_out.crc_ok       = (crc_rx == r_crc);
                        n_param_cnt        = '0;
                        n_window           = '0;
                    end
                end
            endcase
        end

        n_out_valid = (r_out_valid && !o_res.ready) || res_emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_window    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_window    <= n_window;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id        <= n_id;
        r_len       <= n_len;
        r_instr     <= n_instr;
        r_param_cnt <= n_param_cnt;
        r_crc       <= n_crc;
        r_crc_lo    <= n_crc_lo;
        if (res_emit) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.result_kind      = r_out.result_kind;
    assign o_res.data_byte        = r_out.data_byte;
    assign o_res.param_index      = r_out.param_index;
    assign o_res.frame_id         = r_out.frame_id;
    assign o_res.instruction_code = r_out.instruction_code;
    assign o_res.length_value     = r_out.length_value;
    assign o_res.crc_received     = r_out.crc_received;
    assign o_res.crc_ok           = r_out.crc_ok;
    assign o_res.addressed        = r_out.addressed;
    assign o_res.length_ok        = r_out.length_ok;

    // Parameter-byte results never carry CRC information.
    a_param_no_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.result_kind == KIND_PARAM)
            |-> (r_out.crc_ok == 1'b0 && r_out.crc_received == '0))
        else $error("parameter result carries CRC fields");

    // The parameter counter stays inside the packet length.
    a_param_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PARAM) |-> (r_param_cnt < r_len))
        else $error("parameter counter ran past packet length");

    // In the CRC phase the counter only marks whether the low byte is in.
    a_crc_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CRC) |-> (r_param_cnt <= 16'd1))
        else $error("CRC byte counter out of range");

    // A held byte that is not processed stays put.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !proc) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("held input byte lost or changed");

    // A result is emitted only from the parameter or CRC phase.
    a_emit_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_emit |-> (r_phase == PH_PARAM || r_phase == PH_CRC))
        else $error("result emitted outside packet body");

endmodule

// ----- tb/sv/servo_packet_deframer_checker.sv -----
// Scoreboard for the servo packet deframer, plus a small package with the CRC step the
// stimulus also needs. Depends on spd_pkg and the channel interfaces in spd_ifs.sv.
package spd_tb_pkg;
    import spd_pkg::*;

    // Bit-serial CRC-16, MSB first.
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction
endpackage

module servo_packet_deframer_checker import spd_pkg::*, spd_tb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    spd_rx_if                    rx_mon,
    spd_res_if                   res_mon,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_data,
    output int                   o_mismatches,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    // Shadow of the parser.
    t_phase      phase;
    logic [15:0] hdr_window;
    logic [7:0]  pkt_id;
    logic [15:0] pkt_len;
    logic [7:0]  pkt_instr;
    logic [15:0] byte_count;
    logic [15:0] crc_acc;
    logic [7:0]  crc_lo;
    logic [7:0]  dev_id;
    logic [15:0] max_len;

    t_result expected_q[$];

    initial begin
        o_mismatches = 0;
        o_pending = 0;
    end

    function automatic logic [15:0] params_due(input logic [15:0] len, input logic [15:0] limit);
        if (len > limit || len <= PARAM_OVERHEAD) begin
            return 16'd0;
        end
        return len - PARAM_OVERHEAD;
    endfunction

    function automatic t_result frame_fields();
        t_result r;
        r = '0;
        r.frame_id = pkt_id;
        r.instruction_code = pkt_instr;
        r.length_value = pkt_len;
        r.addressed = (pkt_id == dev_id);
        r.length_ok = (pkt_len <= max_len);
        return r;
    endfunction

    task automatic report(input string what);
        o_mismatches++;
        if (o_mismatches <= MAX_REPORTS) begin
            $display("[%0t] checker: %s", $time, what);
        end
    endtask

    task automatic parse_byte(input logic [7:0] b);
        t_result r;
        logic [15:0] rx_crc;
        case (phase)
            PH_HUNT: begin
                if ({hdr_window, b} == HDR_WORD) begin
                    hdr_window = '0;
                    crc_acc = crc16_step(crc16_step(crc16_step(16'h0000, 8'hFF), 8'hFF), 8'hFD);
                    phase = PH_RSV;
                end else begin
                    hdr_window = {hdr_window[7:0], b};
                end
            end
            PH_RSV: begin
                crc_acc = crc16_step(crc_acc, b);
                phase = PH_ID;
            end
            PH_ID: begin
                crc_acc = crc16_step(crc_acc, b);
                pkt_id = b;
                phase = PH_LENL;
            end
            PH_LENL: begin
                crc_acc = crc16_step(crc_acc, b);
                pkt_len = {8'h00, b};
                phase = PH_LENH;
            end
            PH_LENH: begin
                crc_acc = crc16_step(crc_acc, b);
                pkt_len[15:8] = b;
                phase = PH_INSTR;
            end
            PH_INSTR: begin
                crc_acc = crc16_step(crc_acc, b);
                pkt_instr = b;
                byte_count = '0;
                phase = (params_due(pkt_len, max_len) != 0) ? PH_PARAM : PH_CRC;
            end
            PH_PARAM: begin
                crc_acc = crc16_step(crc_acc, b);
                r = frame_fields();
                r.result_kind = KIND_PARAM;
                r.data_byte = b;
                r.param_index = byte_count;
                expected_q.push_back(r);
                byte_count = byte_count + 16'd1;
                if (byte_count >= params_due(pkt_len, max_len)) begin
                    byte_count = '0;
                    phase = PH_CRC;
                end
            end
            PH_CRC: begin
                if (byte_count == 0) begin
                    crc_lo = b;
                    byte_count = 16'd1;
                end else begin
                    rx_crc = {b, crc_lo};
                    r = frame_fields();
                    r.result_kind = KIND_END;
                    r.crc_received = rx_crc;
                    r.crc_ok = (rx_crc == crc_acc);
                    expected_q.push_back(r);
                    byte_count = '0;
                    hdr_window = '0;
                    phase = PH_HUNT;
                end
            end
        endcase
    endtask

    task automatic check_result();
        t_result got;
        t_result want;
        string   bad;
        got.result_kind = t_kind'(res_mon.result_kind);
        got.data_byte = res_mon.data_byte;
        got.param_index = res_mon.param_index;
        got.frame_id = res_mon.frame_id;
        got.instruction_code = res_mon.instruction_code;
        got.length_value = res_mon.length_value;
        got.crc_received = res_mon.crc_received;
        got.crc_ok = res_mon.crc_ok;
        got.addressed = res_mon.addressed;
        got.length_ok = res_mon.length_ok;
        if (expected_q.size() == 0) begin
            report($sformatf("unexpected item %p", got));
        end else begin
            want = expected_q.pop_front();
            bad = "";
            if (got.result_kind !== want.result_kind) bad = {bad, " result_kind"};
            if (got.data_byte !== want.data_byte) bad = {bad, " data_byte"};
            if (got.param_index !== want.param_index) bad = {bad, " param_index"};
            if (got.frame_id !== want.frame_id) bad = {bad, " frame_id"};
            if (got.instruction_code !== want.instruction_code) bad = {bad, " instruction_code"};
            if (got.length_value !== want.length_value) bad = {bad, " length_value"};
            if (got.crc_received !== want.crc_received) bad = {bad, " crc_received"};
            if (got.crc_ok !== want.crc_ok) bad = {bad, " crc_ok"};
            if (got.addressed !== want.addressed) bad = {bad, " addressed"};
            if (got.length_ok !== want.length_ok) bad = {bad, " length_ok"};
            if (bad != "") begin
                report($sformatf("mismatch in%s\n    expected %p\n    actual   %p", bad, want, got));
            end
        end
    endtask

    // Compare first: a result never belongs to a byte taken at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase = PH_HUNT;
            hdr_window = '0;
            pkt_id = '0;
            pkt_len = '0;
            pkt_instr = '0;
            byte_count = '0;
            crc_acc = '0;
            crc_lo = '0;
            dev_id = RST_DEVICE_ID;
            max_len = RST_MAX_LENGTH;
            expected_q.delete();
        end else begin
            if (res_mon.valid && res_mon.ready) begin
                check_result();
            end
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    CFG_DEVICE_ID:  dev_id = i_cfg_data[7:0];
                    CFG_MAX_LENGTH: max_len = i_cfg_data;
                endcase
            end
            if (rx_mon.valid && rx_mon.ready) begin
                parse_byte(rx_mon.rx_byte);
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// ----- tb/sv/servo_packet_deframer_tb.sv -----
// Testbench top for the servo packet deframer: clock, reset, byte stimulus and verdict.
// Depends on spd_pkg, spd_ifs.sv, the deframer RTL and the checker/spd_tb_pkg file.
module servo_packet_deframer_tb import spd_pkg::*, spd_tb_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD   = 300;  // receiver hold-off that backs the block up
    localparam int DRAIN_WAIT  = 10;   // cycles past the last result before a config write
    localparam int RESET_CYCLES = 11;

    logic          clk;
    logic          rst_n;
    logic          cfg_we;
    t_cfg_reg      cfg_idx;
    logic [15:0]   cfg_data;
    int            mismatches;
    int            pending;

    // Stimulus-side copy of the settings; only used to build well-formed packets.
    logic [7:0]    cur_id;
    logic [15:0]   cur_max;

    bit            idle_on;    // random gaps on both channels
    bit            hold_long;  // request one long receiver hold-off
    int            n_sent;     // bytes accepted so far

    spd_rx_if  rx_if ();
    spd_res_if res_if ();

    servo_packet_deframer u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_rx       (rx_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    servo_packet_deframer_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .rx_mon       (rx_if),
        .res_mon      (res_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // Offer one byte and hold it until the block takes it. Returns at the accepting edge
    // with valid still high, so the caller must either offer the next byte or drop valid
    // in that same step.
    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        rx_if.valid <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge clk); while (!rx_if.ready);
        n_sent++;
    endtask

    task automatic send_crc(input logic [7:0] b, inout logic [15:0] crc);
        crc = crc16_step(crc, b);
        send_byte(b);
    endtask

    // Full frame: header, reserved, id, length, instruction, as many parameter bytes as
    // the block will read under the current limit, then the CRC (optionally corrupted).
    // With header_like set the parameters are made of FF/FD to look like a header.
    task automatic send_packet(input logic [7:0] pid, input logic [15:0] plen,
                               input logic [7:0] pinstr, input bit bad_crc,
                               input bit header_like);
        logic [15:0] crc;
        int          n_par;
        logic [7:0]  b;
        crc = 16'h0000;
        n_par = (plen <= cur_max && plen > PARAM_OVERHEAD) ? int'(plen - PARAM_OVERHEAD) : 0;
        send_crc(8'hFF, crc);
        send_crc(8'hFF, crc);
        send_crc(8'hFD, crc);
        send_crc(8'($urandom), crc);
        send_crc(pid, crc);
        send_crc(plen[7:0], crc);
        send_crc(plen[15:8], crc);
        send_crc(pinstr, crc);
        for (int i = 0; i < n_par; i++) begin
            if (header_like) begin
                b = ($urandom_range(0, 2) == 0) ? 8'hFD : 8'hFF;
            end else begin
                b = 8'($urandom);
            end
            send_crc(b, crc);
        end
        if (bad_crc) begin
            crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
        end
        send_byte(crc[7:0]);
        send_byte(crc[15:8]);
    endtask

    // Mostly small lengths; cap any length that would be read at 60 so runs stay quick.
    task automatic random_packet();
        logic [7:0]  pid;
        logic [15:0] plen;
        pid = ($urandom_range(0, 2) == 0) ? cur_id : 8'($urandom);
        case ($urandom_range(0, 7))
            0:       plen = 16'($urandom_range(0, 3));
            1:       plen = cur_max;
            2:       plen = cur_max + 16'd1;
            3:       plen = 16'($urandom);
            default: plen = 16'($urandom_range(0, 24));
        endcase
        if (plen <= cur_max && plen > 16'd60) begin
            plen = 16'($urandom_range(4, 60));
        end
        send_packet(pid, plen, 8'($urandom), $urandom_range(0, 4) == 0,
                    $urandom_range(0, 3) == 0);
    endtask

    // Line noise, or a header followed by a truncated frame that the next packet
    // will be read into.
    task automatic send_junk(input bit with_header);
        int n;
        if (with_header) begin
            send_byte(8'hFF);
            send_byte(8'hFF);
            send_byte(8'hFD);
            n = $urandom_range(0, 6);
        end else begin
            n = $urandom_range(1, 8);
        end
        repeat (n) begin
            send_byte(($urandom_range(0, 2) == 0) ? (($urandom_range(0, 1) == 1) ? 8'hFF : 8'hFD)
                                                  : 8'($urandom));
        end
    endtask

    // Mostly well-formed frames with random content; noise only where the length limit
    // keeps a misread frame short.
    task automatic random_phase(input int n_bytes, input bit allow_noise);
        int start;
        int pick;
        start = n_sent;
        while (n_sent - start < n_bytes) begin
            pick = $urandom_range(0, 9);
            if (allow_noise && pick == 0) begin
                send_junk(1'b0);
            end else if (allow_noise && pick == 1) begin
                send_junk(1'b1);
            end else begin
                random_packet();
            end
        end
    endtask

    // Drop valid, let the checker see the last byte, wait for every expected item, then
    // give the pipeline time to settle.
    task automatic drain();
        rx_if.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Write both registers on back-to-back edges; junk in the unused data bits of the
    // id write must be dropped by the block.
    task automatic set_config(input logic [7:0] dev, input logic [15:0] maxl);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_DEVICE_ID;
        cfg_data <= {8'($urandom), dev};
        @(posedge clk);
        cfg_idx <= CFG_MAX_LENGTH;
        cfg_data <= maxl;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_id = dev;
        cur_max = maxl;
    endtask

    // Result side: random stalls, one long hold-off on request, always ready when idling
    // is off.
    initial begin
        res_if.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_long) begin
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_long = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    initial begin
        rst_n <= 1'b0;
        rx_if.valid <= 1'b0;
        rx_if.rx_byte <= '0;
        cfg_we <= 1'b0;
        cfg_idx <= CFG_DEVICE_ID;
        cfg_data <= '0;
        cur_id = RST_DEVICE_ID;
        cur_max = RST_MAX_LENGTH;
        idle_on = 1'b1;
        hold_long = 1'b0;
        n_sent = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames under the reset settings (id 5, limit 29).
        send_packet(8'd5, 16'd3, 8'h01, 1'b0, 1'b0);       // no parameters, addressed
        send_packet(8'd0, 16'd0, 8'hFF, 1'b0, 1'b0);       // short length
        send_packet(8'hFF, 16'd2, 8'h80, 1'b0, 1'b0);      // short length, top id
        send_packet(8'd5, 16'd4, 8'h55, 1'b1, 1'b0);       // one parameter, bad CRC
        send_packet(8'd5, 16'd29, 8'h03, 1'b0, 1'b1);      // at the limit, header-like data
        send_packet(8'd7, 16'd30, 8'h02, 1'b0, 1'b0);      // just over the limit
        send_packet(8'd5, 16'hFFFF, 8'h00, 1'b0, 1'b0);    // largest length, not read
        send_byte(8'hFF);                                  // FF FF FF FD: header still found
        send_packet(8'd5, 16'd6, 8'h02, 1'b0, 1'b1);
        send_byte(8'hFF);                                  // partial header broken by 00
        send_byte(8'hFF);
        send_byte(8'h00);
        send_packet(8'd5, 16'd5, 8'h03, 1'b0, 1'b0);
        drain();

        // Limit zero: nothing is ever read as a parameter.
        set_config(8'd0, 16'd0);
        random_phase(120, 1'b1);
        drain();

        // Widest settings; frames only, since a misread length could run very long.
        set_config(8'hFF, 16'hFFFF);
        random_phase(120, 1'b0);
        drain();

        // Limits right around the parameter overhead.
        set_config(8'($urandom), 16'd3);
        random_phase(100, 1'b1);
        drain();
        set_config(8'($urandom), 16'd4);
        random_phase(100, 1'b1);
        drain();

        // Back the block up with a long receiver hold-off while bytes keep coming.
        set_config(8'($urandom), 16'($urandom_range(8, 40)));
        hold_long = 1'b1;
        random_phase(150, 1'b1);

        // Final stretch at full rate on both sides.
        idle_on = 1'b0;
        random_phase(80, 1'b1);
        drain();

        if (mismatches == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/spd_pkg.sv
src/spd_ifs.sv
src/servo_packet_deframer.sv
tb/sv/servo_packet_deframer_checker.sv
tb/sv/servo_packet_deframer_tb.sv
